[hdl/set_intersection_dedup_core_assert.svh]
// Assertion macros for the set intersection core.
// Needs clk_i and rst_ni in the scope that expands them.
`ifndef SET_INTERSECTION_DEDUP_CORE_ASSERT_SVH
`define SET_INTERSECTION_DEDUP_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SID_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sid_pkg.sv]
// Shared types, constants and microcode ROM for the set intersection core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sid_pkg;

  localparam int unsigned SET_DEPTH_DEF = 64;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned STEP_W        = 4;

  // Microprogram step addresses
  localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_OUTER    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_SCAN2    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_CMP2     = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SCANF    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_CMPF     = 4'd5;
  localparam logic [STEP_W-1:0] STEP_EMPTYCHK = 4'd6;
  localparam logic [STEP_W-1:0] STEP_EMPTY    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_EMITRD   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EMITOUT  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_ADVANCE  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_FINISH   = 4'd11;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,         // cond: clear i and found count
    OP_RD_FIRST,     // !cond: read first[i], j = 0
    OP_RD_SECOND,    // !cond: read second[j]; cond: i++
    OP_CMP_SECOND,   // cond: k = 0; !cond: j++
    OP_SCAN_FOUND,   // cond: append to found, i++; !cond: read found[k]
    OP_CMP_FOUND,    // cond: i++; !cond: k++
    OP_K_CLEAR,
    OP_OUT_EMPTY,    // cond: load empty result
    OP_RD_EMIT,      // read found[k]
    OP_OUT_LOAD,     // cond: load result, k++
    OP_CLEAR         // end of run: counts and drop flag to zero
  } op_e;

  typedef enum logic [3:0] {
    COND_ALWAYS,
    COND_START,
    COND_I_END,
    COND_J_END,
    COND_MATCH_SECOND,
    COND_K_END,
    COND_MATCH_FOUND,
    COND_FCNT_ZERO,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] jt;
    logic [STEP_W-1:0] jf;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic i_end;
    logic j_end;
    logic match_second;
    logic k_end;
    logic match_found;
    logic fcnt_zero;
    logic out_free;
  } status_t;

  typedef struct packed {
    op_e  op;
    logic cond_true;
    logic idle;
  } ctrl_t;

  typedef struct packed {
    logic                     to_second;
    logic signed [DATA_W-1:0] value;
    logic                     no_element;
    logic                     close_set;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     is_last;
    logic                     is_empty;
    logic                     overflow;
  } out_item_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, jt: STEP_IDLE, jf: STEP_IDLE};
    case (step)
      STEP_IDLE:     w = '{op: OP_INIT, cond: COND_START,
                           jt: STEP_OUTER, jf: STEP_IDLE};
      STEP_OUTER:    w = '{op: OP_RD_FIRST, cond: COND_I_END,
                           jt: STEP_EMPTYCHK, jf: STEP_SCAN2};
      STEP_SCAN2:    w = '{op: OP_RD_SECOND, cond: COND_J_END,
                           jt: STEP_OUTER, jf: STEP_CMP2};
      STEP_CMP2:     w = '{op: OP_CMP_SECOND, cond: COND_MATCH_SECOND,
                           jt: STEP_SCANF, jf: STEP_SCAN2};
      STEP_SCANF:    w = '{op: OP_SCAN_FOUND, cond: COND_K_END,
                           jt: STEP_OUTER, jf: STEP_CMPF};
      STEP_CMPF:     w = '{op: OP_CMP_FOUND, cond: COND_MATCH_FOUND,
                           jt: STEP_OUTER, jf: STEP_SCANF};
      STEP_EMPTYCHK: w = '{op: OP_K_CLEAR, cond: COND_FCNT_ZERO,
                           jt: STEP_EMPTY, jf: STEP_EMITRD};
      STEP_EMPTY:    w = '{op: OP_OUT_EMPTY, cond: COND_OUT_FREE,
                           jt: STEP_FINISH, jf: STEP_EMPTY};
      STEP_EMITRD:   w = '{op: OP_RD_EMIT, cond: COND_ALWAYS,
                           jt: STEP_EMITOUT, jf: STEP_EMITOUT};
      STEP_EMITOUT:  w = '{op: OP_OUT_LOAD, cond: COND_OUT_FREE,
                           jt: STEP_ADVANCE, jf: STEP_EMITOUT};
      STEP_ADVANCE:  w = '{op: OP_NOP, cond: COND_K_END,
                           jt: STEP_FINISH, jf: STEP_EMITRD};
      STEP_FINISH:   w = '{op: OP_CLEAR, cond: COND_ALWAYS,
                           jt: STEP_IDLE, jf: STEP_IDLE};
      default:       w = '{op: OP_NOP, cond: COND_ALWAYS,
                           jt: STEP_IDLE, jf: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hdl/sid_seq.sv]
// Microcode sequencer: step counter, ROM lookup and conditional jump.
// Depends on sid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sid_seq import sid_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  logic [STEP_W-1:0] pc_q, pc_d;
  ucode_t            uw;
  logic              cond_true;

  assign uw = ucode_rom(pc_q);

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:       cond_true = 1'b1;
      COND_START:        cond_true = status_i.start;
      COND_I_END:        cond_true = status_i.i_end;
      COND_J_END:        cond_true = status_i.j_end;
      COND_MATCH_SECOND: cond_true = status_i.match_second;
      COND_K_END:        cond_true = status_i.k_end;
      COND_MATCH_FOUND:  cond_true = status_i.match_found;
      COND_FCNT_ZERO:    cond_true = status_i.fcnt_zero;
      COND_OUT_FREE:     cond_true = status_i.out_free;
      default:           cond_true = 1'b0;
    endcase
  end

  assign pc_d = cond_true ? uw.jt : uw.jf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op        = uw.op;
  assign ctrl_o.cond_true = cond_true;
  assign ctrl_o.idle      = (pc_q == STEP_IDLE);

endmodule

`default_nettype wire

[hdl/set_intersection_dedup_core.sv]
// Set intersection core with duplicate removal: load stores, datapath, output register.
// Depends on sid_pkg, sid_seq and set_intersection_dedup_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "set_intersection_dedup_core_assert.svh"

// Loads two sets of up to SET_DEPTH signed 32-bit elements, one per input
// transfer, into on-chip stores; elements past SET_DEPTH are dropped and the
// overflow flag of the run goes high. Loading runs at one transfer per cycle.
// The transfer that closes the second set (to_second=1, close_set=1) starts
// the compare phase, during which in_stall_o stays high. Every value of the
// first set found in the second set is then given once, in order of first
// appearance in the first set, with is_last on the final one; an empty
// intersection gives a single transfer with is_empty and is_last set.
// The compare phase is run by a small microcoded sequencer over single-port
// stores with registered reads, so each second-set probe is a read step and
// then a compare step, and each found-list probe is a read step and then a
// compare step as well. in_stall_o drops only once the last result has been
// taken into the output register, so a stalled output holds the run up.
// Counts and the overflow flag clear at the end of each run. The output
// register lets the last result wait while the next run is being loaded.
module set_intersection_dedup_core import sid_pkg::*; #(
  parameter int unsigned SET_DEPTH = SET_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned CNT_W = $clog2(SET_DEPTH + 1);
  localparam int unsigned IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SET_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  status_t status;
  ctrl_t   ctrl;

  sid_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  logic ct;
  assign ct = ctrl.cond_true;

  // ---------------------------------------------------------------------
  // Load side
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] first_cnt_q, first_cnt_d;
  logic [CNT_W-1:0] second_cnt_q, second_cnt_d;
  logic             dropped_q, dropped_d;
  logic             in_acc, has_elem, wr_first, wr_second, drop;

  assign in_stall_o = ~ctrl.idle;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign has_elem   = in_acc & ~in_item_i.no_element;
  assign wr_first   = has_elem & ~in_item_i.to_second & (first_cnt_q != DEPTH_C);
  assign wr_second  = has_elem &  in_item_i.to_second & (second_cnt_q != DEPTH_C);
  assign drop       = has_elem & ~wr_first & ~wr_second;

  always_comb begin
    first_cnt_d  = first_cnt_q;
    second_cnt_d = second_cnt_q;
    dropped_d    = dropped_q;
    if (ctrl.op == OP_CLEAR) begin
      first_cnt_d  = '0;
      second_cnt_d = '0;
      dropped_d    = 1'b0;
    end else begin
      if (wr_first)  first_cnt_d  = first_cnt_q + ONE_C;
      if (wr_second) second_cnt_d = second_cnt_q + ONE_C;
      if (drop)      dropped_d    = 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Walk counters: i over first set, j over second, k over found list
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d, fcnt_q, fcnt_d;
  logic             rd_first, rd_second, rd_found, wr_found;
  logic             load_res, load_empty;

  assign rd_first   = (ctrl.op == OP_RD_FIRST)   & ~ct;
  assign rd_second  = (ctrl.op == OP_RD_SECOND)  & ~ct;
  assign rd_found   = ((ctrl.op == OP_SCAN_FOUND) & ~ct) | (ctrl.op == OP_RD_EMIT);
  assign wr_found   = (ctrl.op == OP_SCAN_FOUND) &  ct;
  assign load_res   = (ctrl.op == OP_OUT_LOAD)   &  ct;
  assign load_empty = (ctrl.op == OP_OUT_EMPTY)  &  ct;

  always_comb begin
    i_d    = i_q;
    j_d    = j_q;
    k_d    = k_q;
    fcnt_d = fcnt_q;
    case (ctrl.op)
      OP_INIT: begin
        if (ct) begin
          i_d    = '0;
          fcnt_d = '0;
        end
      end
      OP_RD_FIRST: begin
        if (!ct) j_d = '0;
      end
      OP_RD_SECOND: begin
        if (ct) i_d = i_q + ONE_C;
      end
      OP_CMP_SECOND: begin
        if (ct) k_d = '0;
        else    j_d = j_q + ONE_C;
      end
      OP_SCAN_FOUND: begin
        if (ct) begin
          fcnt_d = fcnt_q + ONE_C;
          i_d    = i_q + ONE_C;
        end
      end
      OP_CMP_FOUND: begin
        if (ct) i_d = i_q + ONE_C;
        else    k_d = k_q + ONE_C;
      end
      OP_K_CLEAR: begin
        k_d = '0;
      end
      OP_OUT_LOAD: begin
        if (ct) k_d = k_q + ONE_C;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Stores, registered reads
  // ---------------------------------------------------------------------
  logic [DATA_W-1:0] first_mem  [SET_DEPTH];
  logic [DATA_W-1:0] second_mem [SET_DEPTH];
  logic [DATA_W-1:0] found_mem  [SET_DEPTH];
  logic [DATA_W-1:0] first_rd_q, second_rd_q, found_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_first)  first_mem[first_cnt_q[IDX_W-1:0]]   <= in_item_i.value;
    if (rd_first)  first_rd_q <= first_mem[i_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_second) second_mem[second_cnt_q[IDX_W-1:0]] <= in_item_i.value;
    if (rd_second) second_rd_q <= second_mem[j_q[IDX_W-1:0]];
  end

  // first_rd_q holds the candidate for the whole of its probe
  always_ff @(posedge clk_i) begin
    if (wr_found) found_mem[fcnt_q[IDX_W-1:0]] <= first_rd_q;
    if (rd_found) found_rd_q <= found_mem[k_q[IDX_W-1:0]];
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic      out_valid_q, out_valid_d, out_free;
  out_item_t out_item_q, out_item_d;
  logic      is_last;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign is_last  = (CNT_W'(k_q + ONE_C) == fcnt_q);

  always_comb begin
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (load_res) begin
      out_valid_d             = 1'b1;
      out_item_d.result_value = found_rd_q;
      out_item_d.is_last      = is_last;
      out_item_d.is_empty     = 1'b0;
      out_item_d.overflow     = dropped_q;
    end else if (load_empty) begin
      out_valid_d             = 1'b1;
      out_item_d.result_value = '0;
      out_item_d.is_last      = 1'b1;
      out_item_d.is_empty     = 1'b1;
      out_item_d.overflow     = dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      dropped_q    <= 1'b0;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      fcnt_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      first_cnt_q  <= first_cnt_d;
      second_cnt_q <= second_cnt_d;
      dropped_q    <= dropped_d;
      i_q          <= i_d;
      j_q          <= j_d;
      k_q          <= k_d;
      fcnt_q       <= fcnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------
  // Status back to the sequencer
  // ---------------------------------------------------------------------
  assign status.start        = in_acc & in_item_i.close_set & in_item_i.to_second;
  assign status.i_end        = (i_q == first_cnt_q);
  assign status.j_end        = (j_q == second_cnt_q);
  assign status.match_second = (second_rd_q == first_rd_q);
  assign status.k_end        = (k_q == fcnt_q);
  assign status.match_found  = (found_rd_q == first_rd_q);
  assign status.fcnt_zero    = (fcnt_q == '0);
  assign status.out_free     = out_free;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `SID_ASSERT_IMPL(a_cnt_bound, 1'b1,
    (first_cnt_q <= DEPTH_C) && (second_cnt_q <= DEPTH_C), "set count past depth")
  `SID_ASSERT_IMPL(a_found_bound, !ctrl.idle, (fcnt_q <= first_cnt_q),
    "found list longer than first set")
  `SID_ASSERT_IMPL(a_empty_last, out_valid_q && out_item_q.is_empty,
    out_item_q.is_last, "empty result not marked last")
  `SID_ASSERT_NEXT(a_clear_run, ctrl.op == OP_CLEAR,
    (first_cnt_q == '0) && (second_cnt_q == '0) && !dropped_q && ctrl.idle,
    "run state not cleared at end of run")

endmodule

`default_nettype wire
